@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define QG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define QG_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ design/qg_pkg.sv @@
// Fixed widths and constants of the quadrilateral geometry block.
package qg_pkg;

   localparam int CROSS_W      = 32;
   localparam int AREA_W       = 34;
   localparam int MID_W        = 17;
   localparam int SPAN_W       = 16;
   localparam int CAPPED_W     = 41;
   localparam int SUM_W        = 43;

   localparam logic [AREA_W-1:0]   AREA_MAX  = '1;
   localparam logic [CAPPED_W-1:0] QUOT_CAP  = 41'd1099511627776;

endpackage

@@ design/qg_div.sv @@
// Pipelined restoring divider: two dividends over one divisor, one quotient bit per stage.
module qg_div #(
   parameter int NUM_W  = 52,
   parameter int DEN_W  = 35,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num_x,
   input  logic [NUM_W-1:0]  in_num_y,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo_x,
   output logic [NUM_W-1:0]  out_quo_y,
   output logic [SIDE_W-1:0] out_side
);

   // stage inputs: index s feeds stage s
   logic              pv   [NUM_W];
   logic [DEN_W-1:0]  prx  [NUM_W];
   logic [DEN_W-1:0]  pry  [NUM_W];
   logic [NUM_W-1:0]  pdx  [NUM_W];
   logic [NUM_W-1:0]  pdy  [NUM_W];
   logic [NUM_W-1:0]  pqx  [NUM_W];
   logic [NUM_W-1:0]  pqy  [NUM_W];
   logic [DEN_W-1:0]  pden [NUM_W];
   logic [SIDE_W-1:0] pside[NUM_W];

   // stage registers
   logic              v_ff   [NUM_W];
   logic [DEN_W-1:0]  rx_ff  [NUM_W];
   logic [DEN_W-1:0]  ry_ff  [NUM_W];
   logic [NUM_W-1:0]  dx_ff  [NUM_W];
   logic [NUM_W-1:0]  dy_ff  [NUM_W];
   logic [NUM_W-1:0]  qx_ff  [NUM_W];
   logic [NUM_W-1:0]  qy_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff [NUM_W];
   logic [SIDE_W-1:0] side_ff[NUM_W];

   genvar s;
   generate
      for (s = 0; s < NUM_W; s++) begin : g_stage
         logic [DEN_W:0]   shx;
         logic [DEN_W:0]   shy;
         logic             gex;
         logic             gey;
         logic [DEN_W-1:0] rx_in;
         logic [DEN_W-1:0] ry_in;

         // feed the first stage from the ports, the rest from the stage before
         if (s == 0) begin : g_first
            assign pv[s]    = in_valid;
            assign prx[s]   = '0;
            assign pry[s]   = '0;
            assign pdx[s]   = in_num_x;
            assign pdy[s]   = in_num_y;
            assign pqx[s]   = '0;
            assign pqy[s]   = '0;
            assign pden[s]  = in_den;
            assign pside[s] = in_side;
         end else begin : g_next
            assign pv[s]    = v_ff[s-1];
            assign prx[s]   = rx_ff[s-1];
            assign pry[s]   = ry_ff[s-1];
            assign pdx[s]   = dx_ff[s-1];
            assign pdy[s]   = dy_ff[s-1];
            assign pqx[s]   = qx_ff[s-1];
            assign pqy[s]   = qy_ff[s-1];
            assign pden[s]  = den_ff[s-1];
            assign pside[s] = side_ff[s-1];
         end

         // shift in the next dividend bit and try the subtract
         assign shx   = {prx[s], pdx[s][NUM_W-1]};
         assign shy   = {pry[s], pdy[s][NUM_W-1]};
         assign gex   = shx >= {1'b0, pden[s]};
         assign gey   = shy >= {1'b0, pden[s]};
         assign rx_in = gex ? DEN_W'(shx - {1'b0, pden[s]}) : shx[DEN_W-1:0];
         assign ry_in = gey ? DEN_W'(shy - {1'b0, pden[s]}) : shy[DEN_W-1:0];

         // advance valid
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[s] <= 1'b0;
            end else if (adv) begin
               v_ff[s] <= pv[s];
            end
         end

         // advance payload
         always_ff @(posedge clock) begin
            if (adv) begin
               rx_ff[s]   <= rx_in;
               ry_ff[s]   <= ry_in;
               dx_ff[s]   <= {pdx[s][NUM_W-2:0], 1'b0};
               dy_ff[s]   <= {pdy[s][NUM_W-2:0], 1'b0};
               qx_ff[s]   <= {pqx[s][NUM_W-2:0], gex};
               qy_ff[s]   <= {pqy[s][NUM_W-2:0], gey};
               den_ff[s]  <= pden[s];
               side_ff[s] <= pside[s];
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[NUM_W-1];
   assign out_quo_x = qx_ff[NUM_W-1];
   assign out_quo_y = qy_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

@@ design/quadrilateral_geometry.sv @@
// Top level: diagonal intersection, shoelace area and bounding box of a quadrilateral.
//
//   channel | ports        | direction | payload
//   --------+--------------+-----------+-----------------------------------------
//   request | req_valid    | in        | req_vertex0_x .. req_vertex3_y
//   result  | rsp_valid    | out       | rsp_cross_x/y, rsp_parallel, rsp_area,
//           |              |           | rsp_box_mid_x/y, rsp_box_width/height
//
// One item is taken every cycle unless req_stall is high. The restoring divider
// resolves one quotient bit per stage.
// Reset clears the valid bits of every stage and the result register.
// A stalled result freezes the whole pipeline; req_stall rises only then.
module quadrilateral_geometry #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [COORD_BITS-1:0]       req_vertex0_x,
   input  logic signed [COORD_BITS-1:0]       req_vertex0_y,
   input  logic signed [COORD_BITS-1:0]       req_vertex1_x,
   input  logic signed [COORD_BITS-1:0]       req_vertex1_y,
   input  logic signed [COORD_BITS-1:0]       req_vertex2_x,
   input  logic signed [COORD_BITS-1:0]       req_vertex2_y,
   input  logic signed [COORD_BITS-1:0]       req_vertex3_x,
   input  logic signed [COORD_BITS-1:0]       req_vertex3_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [qg_pkg::CROSS_W-1:0]  rsp_cross_x,
   output logic signed [qg_pkg::CROSS_W-1:0]  rsp_cross_y,
   output logic                               rsp_parallel,
   output logic        [qg_pkg::AREA_W-1:0]   rsp_area,
   output logic signed [qg_pkg::MID_W-1:0]    rsp_box_mid_x,
   output logic signed [qg_pkg::MID_W-1:0]    rsp_box_mid_y,
   output logic        [qg_pkg::SPAN_W-1:0]   rsp_box_width,
   output logic        [qg_pkg::SPAN_W-1:0]   rsp_box_height
);
   import qg_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int DIF_W  = C + 1;
   localparam int PRD_W  = 2 * C + 2;
   localparam int DEN_W  = 2 * C + 3;
   localparam int AP_W   = 2 * C;
   localparam int ASUM_W = 2 * C + 3;
   localparam int NUM_W  = 3 * C + 4;
   localparam int LO_W   = C + 2;
   localparam int HI_W   = DEN_W - LO_W;
   localparam int PPL_W  = LO_W + DIF_W;
   localparam int PPH_W  = HI_W + DIF_W;
   localparam int AXW    = ASUM_W > AREA_W ? ASUM_W : AREA_W;
   localparam int BXW    = DIF_W > MID_W ? DIF_W : MID_W;
   localparam int SPW    = DIF_W > SPAN_W ? DIF_W : SPAN_W;
   localparam int QCW    = NUM_W > CAPPED_W ? NUM_W : CAPPED_W;
   localparam int SIDE_W = 3 + 2 * C + AREA_W + 2 * MID_W + 2 * SPAN_W;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

   logic adv;

   // move everything unless a finished result is held
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // ---------------- stage 1: capture vertices
   logic                s1_v_ff;
   logic signed [C-1:0] s1_x_ff [4];
   logic signed [C-1:0] s1_y_ff [4];

   // ---------------- stage 2: differences, area products, min and max
   logic                    s2_v_ff;
   logic signed [DIF_W-1:0] s2_dx1_ff, s2_dy1_ff, s2_dx2_ff, s2_dy2_ff, s2_ex_ff, s2_ey_ff;
   logic signed [AP_W-1:0]  s2_ap_ff [8];
   logic signed [C-1:0]     s2_minx_ff, s2_maxx_ff, s2_miny_ff, s2_maxy_ff;
   logic signed [C-1:0]     s2_bx_ff, s2_by_ff;
   logic signed [AP_W-1:0]  ap_in [8];
   logic signed [C-1:0]     minx_in, maxx_in, miny_in, maxy_in;

   always_comb begin
      minx_in = s1_x_ff[0];
      maxx_in = s1_x_ff[0];
      miny_in = s1_y_ff[0];
      maxy_in = s1_y_ff[0];
      for (int i = 1; i < 4; i++) begin
         if (s1_x_ff[i] < minx_in) minx_in = s1_x_ff[i];
         if (s1_x_ff[i] > maxx_in) maxx_in = s1_x_ff[i];
         if (s1_y_ff[i] < miny_in) miny_in = s1_y_ff[i];
         if (s1_y_ff[i] > maxy_in) maxy_in = s1_y_ff[i];
      end
      for (int i = 0; i < 4; i++) begin
         ap_in[2*i]   = AP_W'(s1_x_ff[i]) * AP_W'(s1_y_ff[(i+1)%4]);
         ap_in[2*i+1] = AP_W'(s1_x_ff[(i+1)%4]) * AP_W'(s1_y_ff[i]);
      end
   end

   // ---------------- stage 3: diagonal products, area sum, box fields
   logic                    s3_v_ff;
   logic signed [PRD_W-1:0] s3_pd0_ff, s3_pd1_ff, s3_pn0_ff, s3_pn1_ff;
   logic signed [ASUM_W-1:0] s3_asum_ff;
   logic signed [DIF_W-1:0] s3_dx1_ff, s3_dy1_ff;
   logic signed [C-1:0]     s3_bx_ff, s3_by_ff;
   logic [MID_W-1:0]        s3_mx_ff, s3_my_ff;
   logic [SPAN_W-1:0]       s3_wx_ff, s3_hy_ff;
   logic signed [ASUM_W-1:0] asum_in;
   logic signed [DIF_W-1:0] midx_w, midy_w;
   logic signed [BXW-1:0]   midx_e, midy_e;
   logic [DIF_W-1:0]        spanx_w, spany_w;
   logic [SPW-1:0]          spanx_e, spany_e;

   always_comb begin
      asum_in = '0;
      for (int i = 0; i < 4; i++) begin
         asum_in = asum_in + ASUM_W'(s2_ap_ff[2*i]) - ASUM_W'(s2_ap_ff[2*i+1]);
      end
   end

   assign midx_w  = DIF_W'(s2_minx_ff) + DIF_W'(s2_maxx_ff);
   assign midy_w  = DIF_W'(s2_miny_ff) + DIF_W'(s2_maxy_ff);
   assign midx_e  = BXW'(midx_w);
   assign midy_e  = BXW'(midy_w);
   assign spanx_w = DIF_W'(s2_maxx_ff) - DIF_W'(s2_minx_ff);
   assign spany_w = DIF_W'(s2_maxy_ff) - DIF_W'(s2_miny_ff);
   assign spanx_e = SPW'(spanx_w);
   assign spany_e = SPW'(spany_w);

   // ---------------- stage 4: denominator, numerator, magnitudes, signs
   logic                    s4_v_ff;
   logic [DEN_W-1:0]        s4_mden_ff, s4_mnum_ff;
   logic [DIF_W-1:0]        s4_mdx_ff, s4_mdy_ff;
   logic [SIDE_W-1:0]       s4_side_ff;
   logic signed [DEN_W-1:0] den_w, num_w;
   logic [ASUM_W-1:0]       amag;
   logic [AXW-1:0]          amag_e;
   logic [AREA_W-1:0]       area_in;
   logic                    negx_in, negy_in, par_in;

   assign den_w   = DEN_W'(s3_pd0_ff) - DEN_W'(s3_pd1_ff);
   assign num_w   = DEN_W'(s3_pn0_ff) - DEN_W'(s3_pn1_ff);
   assign par_in  = den_w == '0;
   assign negx_in = num_w[DEN_W-1] ^ s3_dx1_ff[DIF_W-1] ^ den_w[DEN_W-1];
   assign negy_in = num_w[DEN_W-1] ^ s3_dy1_ff[DIF_W-1] ^ den_w[DEN_W-1];
   assign amag    = s3_asum_ff[ASUM_W-1] ? ASUM_W'(-s3_asum_ff) : ASUM_W'(s3_asum_ff);
   assign amag_e  = AXW'(amag);
   assign area_in = (amag_e > AXW'(AREA_MAX)) ? AREA_MAX : AREA_W'(amag_e);

   // ---------------- stage 5: partial products of numerator and diagonal
   logic              s5_v_ff;
   logic [PPL_W-1:0]  s5_pxl_ff, s5_pyl_ff;
   logic [PPH_W-1:0]  s5_pxh_ff, s5_pyh_ff;
   logic [DEN_W-1:0]  s5_mden_ff;
   logic [SIDE_W-1:0] s5_side_ff;

   // ---------------- stage 6: full dividends
   logic              s6_v_ff;
   logic [NUM_W-1:0]  s6_nx_ff, s6_ny_ff;
   logic [DEN_W-1:0]  s6_mden_ff;
   logic [SIDE_W-1:0] s6_side_ff;

   // ---------------- divider
   logic              dv_valid;
   logic [NUM_W-1:0]  dv_qx, dv_qy;
   logic [SIDE_W-1:0] dv_side;

   qg_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s6_v_ff),
      .in_num_x  (s6_nx_ff),
      .in_num_y  (s6_ny_ff),
      .in_den    (s6_mden_ff),
      .in_side   (s6_side_ff),
      .out_valid (dv_valid),
      .out_quo_x (dv_qx),
      .out_quo_y (dv_qy),
      .out_side  (dv_side)
   );

   // ---------------- stage 7: cap and sign the quotients
   logic                    dv_negx, dv_negy, dv_par;
   logic signed [C-1:0]     dv_bx, dv_by;
   logic [AREA_W-1:0]       dv_area;
   logic [MID_W-1:0]        dv_mx, dv_my;
   logic [SPAN_W-1:0]       dv_wx, dv_hy;
   logic [QCW-1:0]          qx_e, qy_e;
   logic [CAPPED_W-1:0]     qx_c, qy_c;

   assign {dv_negx, dv_negy, dv_par, dv_bx, dv_by, dv_area, dv_mx, dv_my, dv_wx, dv_hy}
      = dv_side;
   assign qx_e = QCW'(dv_qx);
   assign qy_e = QCW'(dv_qy);
   assign qx_c = (qx_e > QCW'(QUOT_CAP)) ? QUOT_CAP : CAPPED_W'(qx_e);
   assign qy_c = (qy_e > QCW'(QUOT_CAP)) ? QUOT_CAP : CAPPED_W'(qy_e);

   logic                    f_v_ff;
   logic signed [SUM_W-1:0] f_sqx_ff, f_sqy_ff;
   logic                    f_par_ff;
   logic signed [C-1:0]     f_bx_ff, f_by_ff;
   logic [AREA_W-1:0]       f_area_ff;
   logic [MID_W-1:0]        f_mx_ff, f_my_ff;
   logic [SPAN_W-1:0]       f_wx_ff, f_hy_ff;

   // ---------------- stage 8: add base point and saturate
   logic signed [SUM_W-1:0]   sumx, sumy;
   logic signed [CROSS_W-1:0] crx_in, cry_in;

   assign sumx = SUM_W'(f_bx_ff) + f_sqx_ff;
   assign sumy = SUM_W'(f_by_ff) + f_sqy_ff;

   always_comb begin
      if (f_par_ff) begin
         crx_in = '0;
         cry_in = '0;
      end else begin
         crx_in = (sumx > SAT_HI) ? CROSS_W'(SAT_HI) :
                  (sumx < SAT_LO) ? CROSS_W'(SAT_LO) : CROSS_W'(sumx);
         cry_in = (sumy > SAT_HI) ? CROSS_W'(SAT_HI) :
                  (sumy < SAT_LO) ? CROSS_W'(SAT_LO) : CROSS_W'(sumy);
      end
   end

   logic                      rsp_valid_ff;
   logic signed [CROSS_W-1:0] rsp_cross_x_ff, rsp_cross_y_ff;
   logic                      rsp_parallel_ff;
   logic [AREA_W-1:0]         rsp_area_ff;
   logic [MID_W-1:0]          rsp_mx_ff, rsp_my_ff;
   logic [SPAN_W-1:0]         rsp_wx_ff, rsp_hy_ff;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         s5_v_ff      <= 1'b0;
         s6_v_ff      <= 1'b0;
         f_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff      <= req_valid;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         s4_v_ff      <= s3_v_ff;
         s5_v_ff      <= s4_v_ff;
         s6_v_ff      <= s5_v_ff;
         f_v_ff       <= dv_valid;
         rsp_valid_ff <= f_v_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff[0] <= req_vertex0_x;
         s1_y_ff[0] <= req_vertex0_y;
         s1_x_ff[1] <= req_vertex1_x;
         s1_y_ff[1] <= req_vertex1_y;
         s1_x_ff[2] <= req_vertex2_x;
         s1_y_ff[2] <= req_vertex2_y;
         s1_x_ff[3] <= req_vertex3_x;
         s1_y_ff[3] <= req_vertex3_y;

         s2_dx1_ff  <= DIF_W'(s1_x_ff[2]) - DIF_W'(s1_x_ff[0]);
         s2_dy1_ff  <= DIF_W'(s1_y_ff[2]) - DIF_W'(s1_y_ff[0]);
         s2_dx2_ff  <= DIF_W'(s1_x_ff[3]) - DIF_W'(s1_x_ff[1]);
         s2_dy2_ff  <= DIF_W'(s1_y_ff[3]) - DIF_W'(s1_y_ff[1]);
         s2_ex_ff   <= DIF_W'(s1_x_ff[1]) - DIF_W'(s1_x_ff[0]);
         s2_ey_ff   <= DIF_W'(s1_y_ff[1]) - DIF_W'(s1_y_ff[0]);
         s2_ap_ff   <= ap_in;
         s2_minx_ff <= minx_in;
         s2_maxx_ff <= maxx_in;
         s2_miny_ff <= miny_in;
         s2_maxy_ff <= maxy_in;
         s2_bx_ff   <= s1_x_ff[0];
         s2_by_ff   <= s1_y_ff[0];

         s3_pd0_ff  <= PRD_W'(s2_dx1_ff) * PRD_W'(s2_dy2_ff);
         s3_pd1_ff  <= PRD_W'(s2_dy1_ff) * PRD_W'(s2_dx2_ff);
         s3_pn0_ff  <= PRD_W'(s2_ex_ff) * PRD_W'(s2_dy2_ff);
         s3_pn1_ff  <= PRD_W'(s2_ey_ff) * PRD_W'(s2_dx2_ff);
         s3_asum_ff <= asum_in;
         s3_dx1_ff  <= s2_dx1_ff;
         s3_dy1_ff  <= s2_dy1_ff;
         s3_bx_ff   <= s2_bx_ff;
         s3_by_ff   <= s2_by_ff;
         s3_mx_ff   <= midx_e[MID_W-1:0];
         s3_my_ff   <= midy_e[MID_W-1:0];
         s3_wx_ff   <= spanx_e[SPAN_W-1:0];
         s3_hy_ff   <= spany_e[SPAN_W-1:0];

         s4_mden_ff <= den_w[DEN_W-1] ? DEN_W'(-den_w) : DEN_W'(den_w);
         s4_mnum_ff <= num_w[DEN_W-1] ? DEN_W'(-num_w) : DEN_W'(num_w);
         s4_mdx_ff  <= s3_dx1_ff[DIF_W-1] ? DIF_W'(-s3_dx1_ff) : DIF_W'(s3_dx1_ff);
         s4_mdy_ff  <= s3_dy1_ff[DIF_W-1] ? DIF_W'(-s3_dy1_ff) : DIF_W'(s3_dy1_ff);
         s4_side_ff <= {negx_in, negy_in, par_in, s3_bx_ff, s3_by_ff, area_in,
                        s3_mx_ff, s3_my_ff, s3_wx_ff, s3_hy_ff};

         s5_pxl_ff  <= PPL_W'(s4_mnum_ff[LO_W-1:0]) * PPL_W'(s4_mdx_ff);
         s5_pyl_ff  <= PPL_W'(s4_mnum_ff[LO_W-1:0]) * PPL_W'(s4_mdy_ff);
         s5_pxh_ff  <= PPH_W'(s4_mnum_ff[DEN_W-1:LO_W]) * PPH_W'(s4_mdx_ff);
         s5_pyh_ff  <= PPH_W'(s4_mnum_ff[DEN_W-1:LO_W]) * PPH_W'(s4_mdy_ff);
         s5_mden_ff <= s4_mden_ff;
         s5_side_ff <= s4_side_ff;

         s6_nx_ff   <= NUM_W'(s5_pxl_ff) + (NUM_W'(s5_pxh_ff) << LO_W);
         s6_ny_ff   <= NUM_W'(s5_pyl_ff) + (NUM_W'(s5_pyh_ff) << LO_W);
         s6_mden_ff <= s5_mden_ff;
         s6_side_ff <= s5_side_ff;

         f_sqx_ff   <= dv_negx ? -SUM_W'(qx_c) : SUM_W'(qx_c);
         f_sqy_ff   <= dv_negy ? -SUM_W'(qy_c) : SUM_W'(qy_c);
         f_par_ff   <= dv_par;
         f_bx_ff    <= dv_bx;
         f_by_ff    <= dv_by;
         f_area_ff  <= dv_area;
         f_mx_ff    <= dv_mx;
         f_my_ff    <= dv_my;
         f_wx_ff    <= dv_wx;
         f_hy_ff    <= dv_hy;

         rsp_cross_x_ff  <= crx_in;
         rsp_cross_y_ff  <= cry_in;
         rsp_parallel_ff <= f_par_ff;
         rsp_area_ff     <= f_area_ff;
         rsp_mx_ff       <= f_mx_ff;
         rsp_my_ff       <= f_my_ff;
         rsp_wx_ff       <= f_wx_ff;
         rsp_hy_ff       <= f_hy_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cross_x    = rsp_cross_x_ff;
   assign rsp_cross_y    = rsp_cross_y_ff;
   assign rsp_parallel   = rsp_parallel_ff;
   assign rsp_area       = rsp_area_ff;
   assign rsp_box_mid_x  = rsp_mx_ff;
   assign rsp_box_mid_y  = rsp_my_ff;
   assign rsp_box_width  = rsp_wx_ff;
   assign rsp_box_height = rsp_hy_ff;

endmodule

@@ design/qg_checker.sv @@
// Port-level checks of the quadrilateral geometry block and their bind.
module qg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_parallel,
   input logic signed [qg_pkg::CROSS_W-1:0] rsp_cross_x,
   input logic signed [qg_pkg::CROSS_W-1:0] rsp_cross_y,
   input logic signed [qg_pkg::MID_W-1:0]   rsp_box_mid_x,
   input logic        [qg_pkg::SPAN_W-1:0]  rsp_box_width
);
   `include "assert_macros.svh"

   `QG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result item dropped while stalled")
   `QG_ASSERT(a_parallel_zero, clock, reset, rsp_valid && rsp_parallel |-> rsp_cross_x == 0 && rsp_cross_y == 0, "parallel item with nonzero crossing")
   `QG_ASSERT(a_box_parity, clock, reset, rsp_valid |-> rsp_box_mid_x[0] == rsp_box_width[0], "box centre and width disagree")
   `QG_ASSERT(a_no_idle_stall, clock, reset, !rsp_valid |-> !req_stall, "request stalled with empty output")

endmodule

bind quadrilateral_geometry qg_checker u_qg_checker (.*);

@@ tb/sv/quadrilateral_geometry_tb.sv @@
// Testbench for the quadrilateral geometry block: random and directed items checked field by field.
`timescale 1ns / 1ps

module quadrilateral_geometry_tb;
   import qg_pkg::*;

   localparam int CB = 16;
   localparam int LATENCY = 3 * CB + 12;

   typedef struct packed {
      logic signed [CB-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
   } quad_type;

   typedef struct packed {
      logic signed [CROSS_W-1:0] cx, cy;
      logic                      par;
      logic [AREA_W-1:0]         area;
      logic signed [MID_W-1:0]   mx, my;
      logic [SPAN_W-1:0]         w, h;
   } geom_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [CB-1:0] v0x = 0, v0y = 0, v1x = 0, v1y = 0;
   logic signed [CB-1:0] v2x = 0, v2y = 0, v3x = 0, v3y = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [CROSS_W-1:0] rsp_cross_x, rsp_cross_y;
   logic rsp_parallel;
   logic [AREA_W-1:0] rsp_area;
   logic signed [MID_W-1:0] rsp_box_mid_x, rsp_box_mid_y;
   logic [SPAN_W-1:0] rsp_box_width, rsp_box_height;

   geom_type expected_geom[$];
   int errors = 0;
   bit hold_off = 0;
   int burst_left = 0;

   quadrilateral_geometry #(.COORD_BITS(CB)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_vertex0_x(v0x), .req_vertex0_y(v0y),
      .req_vertex1_x(v1x), .req_vertex1_y(v1y),
      .req_vertex2_x(v2x), .req_vertex2_y(v2y),
      .req_vertex3_x(v3x), .req_vertex3_y(v3y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
      .rsp_parallel(rsp_parallel), .rsp_area(rsp_area),
      .rsp_box_mid_x(rsp_box_mid_x), .rsp_box_mid_y(rsp_box_mid_y),
      .rsp_box_width(rsp_box_width), .rsp_box_height(rsp_box_height)
   );

   always #5 clock = ~clock;

   // Point along one diagonal: base + trunc(num*d/denom), saturated to 32 bits
   function automatic logic signed [CROSS_W-1:0] point_on_diag(
         longint base, longint num, longint d, longint denom);
      logic signed [127:0] prod, quot, total;
      logic signed [127:0] cap;
      logic [127:0] mq;
      bit neg;
      cap = 128'sd1 << 40;
      prod = 128'(num) * 128'(d);
      neg = (prod < 0) != (denom < 0);
      mq = (prod < 0 ? -prod : prod) / (denom < 0 ? -128'(denom) : 128'(denom));
      quot = (mq > cap) ? cap : $signed(mq);
      total = 128'(base) + (neg ? -quot : quot);
      if (total > 128'sd2147483647) total = 128'sd2147483647;
      if (total < -128'sd2147483648) total = -128'sd2147483648;
      return total[CROSS_W-1:0];
   endfunction

   // Compute the full geometry of one quadrilateral
   function automatic geom_type quad_geometry(quad_type q);
      geom_type g;
      longint x[4], y[4];
      longint dx1, dy1, dx2, dy2, ex, ey, denom, num, sum;
      longint mnx, mxx, mny, mxy;
      x[0] = q.x0; y[0] = q.y0; x[1] = q.x1; y[1] = q.y1;
      x[2] = q.x2; y[2] = q.y2; x[3] = q.x3; y[3] = q.y3;
      dx1 = x[2] - x[0]; dy1 = y[2] - y[0];
      dx2 = x[3] - x[1]; dy2 = y[3] - y[1];
      ex = x[1] - x[0]; ey = y[1] - y[0];
      denom = dx1 * dy2 - dy1 * dx2;
      num = ex * dy2 - ey * dx2;
      if (denom == 0) begin
         g.cx = 0; g.cy = 0; g.par = 1'b1;
      end else begin
         g.cx = point_on_diag(x[0], num, dx1, denom);
         g.cy = point_on_diag(y[0], num, dy1, denom);
         g.par = 1'b0;
      end
      sum = 0;
      for (int i = 0; i < 4; i++)
         sum += x[i] * y[(i + 1) & 3] - x[(i + 1) & 3] * y[i];
      if (sum < 0) sum = -sum;
      g.area = (sum > longint'(AREA_MAX)) ? AREA_MAX : sum[AREA_W-1:0];
      mnx = x[0]; mxx = x[0]; mny = y[0]; mxy = y[0];
      for (int i = 1; i < 4; i++) begin
         if (x[i] < mnx) mnx = x[i];
         if (x[i] > mxx) mxx = x[i];
         if (y[i] < mny) mny = y[i];
         if (y[i] > mxy) mxy = y[i];
      end
      g.mx = MID_W'(mnx + mxx);
      g.my = MID_W'(mny + mxy);
      g.w = SPAN_W'(mxx - mnx);
      g.h = SPAN_W'(mxy - mny);
      return g;
   endfunction

   // Offer one quadrilateral, holding it until accepted, with bursty gaps
   task automatic send_quad(quad_type q);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1;
      {v0x, v0y, v1x, v1y, v2x, v2y, v3x, v3y} <= q;
      expected_geom.push_back(quad_geometry(q));
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid after the last item of a sequence
   task automatic end_burst();
      req_valid <= 0;
      burst_left = 0;
      @(negedge clock);
   endtask

   // Random coordinate in off-based window of span+1 values
   function automatic logic signed [CB-1:0] rnd_coord(int span, int off);
      return CB'(int'($urandom_range(0, span)) - off);
   endfunction

   function automatic quad_type random_quad(int mode);
      quad_type q;
      q = quad_type'({$urandom, $urandom, $urandom, $urandom});
      case (mode)
         // small coordinates around the origin
         1: begin
            q.x0 = rnd_coord(255, 128);
            q.y0 = rnd_coord(255, 128);
            q.x1 = rnd_coord(255, 128);
            q.y1 = rnd_coord(255, 128);
            q.x2 = rnd_coord(255, 128);
            q.y2 = rnd_coord(255, 128);
            q.x3 = rnd_coord(255, 128);
            q.y3 = rnd_coord(255, 128);
         end
         // parallel diagonals: v3-v1 a multiple of v2-v0
         2: begin
            q.x0 = rnd_coord(2047, 1024);
            q.y0 = rnd_coord(2047, 1024);
            q.x2 = q.x0 + rnd_coord(63, 32);
            q.y2 = q.y0 + rnd_coord(63, 32);
            q.x3 = q.x1 + CB'((q.x2 - q.x0) * 3);
            q.y3 = q.y1 + CB'((q.y2 - q.y0) * 3);
         end
         // near-parallel, intersection far away
         3: begin
            q.x0 = 16'sh8000; q.y0 = '0; q.x2 = 16'sh7fff; q.y2 = 16'sd1;
            q.x1 = 16'sh8000; q.y1 = rnd_coord(2, -1);
            q.x3 = 16'sh7fff; q.y3 = q.y1 + rnd_coord(1, -1);
         end
         default: ;
      endcase
      return q;
   endfunction

   task automatic test_extremes();
      quad_type q;
      send_quad('0);
      send_quad({8{16'sh7fff}});
      send_quad({8{16'sh8000}});
      send_quad({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
      send_quad({16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
                 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000});
      send_quad({16'sh0000, 16'sh0000, 16'sh0010, 16'sh0000,
                 16'sh0010, 16'sh0010, 16'sh0000, 16'sh0010});
      send_quad({16'shffff, 16'sh0001, 16'sh0001, 16'shffff,
                 16'sh0001, 16'sh0001, 16'shffff, 16'shffff});
      q = {16'sh8000, 16'sh0000, 16'sh8000, 16'sh0001,
           16'sh7fff, 16'sh0001, 16'sh7fff, 16'sh0002};
      send_quad(q);
   endtask

   task automatic test_parallel();
      // coincident vertices and collinear diagonals
      send_quad({4{16'sh0123, 16'shff00}});
      send_quad({16'sh0000, 16'sh0000, 16'sh0010, 16'sh0010,
                 16'sh0020, 16'sh0020, 16'sh0030, 16'sh0030});
      for (int i = 0; i < 4; i++) send_quad(random_quad(2));
   endtask

   task automatic test_far_cross();
      for (int i = 0; i < 6; i++) send_quad(random_quad(3));
   endtask

   task automatic test_random(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         send_quad(random_quad(r < 4 ? 0 : r < 7 ? 1 : r < 9 ? 2 : 3));
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1;
      fork
         begin
            repeat (LATENCY + 60) @(negedge clock);
            hold_off = 0;
         end
         begin
            test_random(LATENCY + 40);
            end_burst();
         end
      join
   endtask

   // Stall the result side on its own pattern
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else if (($time / 2000) % 3 == 0) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      geom_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_geom.size() == 0) begin
            $display("%0t: result with none expected", $time);
            errors++;
         end else begin
            e = expected_geom.pop_front();
            if (rsp_cross_x !== e.cx) begin
               $display("%0t: cross_x exp %0d got %0d", $time, e.cx, rsp_cross_x); errors++;
            end
            if (rsp_cross_y !== e.cy) begin
               $display("%0t: cross_y exp %0d got %0d", $time, e.cy, rsp_cross_y); errors++;
            end
            if (rsp_parallel !== e.par) begin
               $display("%0t: parallel exp %0d got %0d", $time, e.par, rsp_parallel); errors++;
            end
            if (rsp_area !== e.area) begin
               $display("%0t: area exp %0d got %0d", $time, e.area, rsp_area); errors++;
            end
            if (rsp_box_mid_x !== e.mx) begin
               $display("%0t: box_mid_x exp %0d got %0d", $time, e.mx, rsp_box_mid_x); errors++;
            end
            if (rsp_box_mid_y !== e.my) begin
               $display("%0t: box_mid_y exp %0d got %0d", $time, e.my, rsp_box_mid_y); errors++;
            end
            if (rsp_box_width !== e.w) begin
               $display("%0t: box_width exp %0d got %0d", $time, e.w, rsp_box_width); errors++;
            end
            if (rsp_box_height !== e.h) begin
               $display("%0t: box_height exp %0d got %0d", $time, e.h, rsp_box_height); errors++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_extremes();
      test_parallel();
      test_far_cross();
      test_backpressure();
      test_random(780);
      end_burst();
      while (expected_geom.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && expected_geom.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
